// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files of the accumulator; only the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sgsm: same-cycle check failed");
`define ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sgsm: next-cycle check failed");
`else
`define ASSERT_IMP(label, ck, rn, ante, cons)
`define ASSERT_NXT(label, ck, rn, ante, cons)
`endif
`endif

// ===== rtl/core/sgsm_pkg.sv =====
// Types and constants of the sparse-grid second-moment accumulator.
`default_nettype none
package sgsm_pkg;

    localparam int DIMS_DEF      = 8;
    localparam int MAX_LEVEL_DEF = 16;
    localparam int LEVEL_W       = 5;
    localparam int SHIFT_W       = 7;

    localparam logic [31:0] ONE_Q24 = 32'h0100_0000;
    localparam logic [63:0] ONE_Q40 = 64'h0000_0100_0000_0000;
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TERM = 1'b1;

    typedef struct packed {
        logic               command;
        logic [2:0]         dimension;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
        logic [4:0]         level;
        logic [15:0]        index;
        logic signed [31:0] coefficient;
        logic               last_dim;
        logic               last_point;
    } item_t;

    typedef struct packed {
        logic signed [63:0] moment_total;
        logic               overflow;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE, S_READ, S_PREP, S_PARAM, S_XSQ, S_XPSET, S_MUL, S_DIV,
        S_RADD, S_RSHF, S_CONV, S_FACC, S_PFSET, S_PSET, S_CPSET, S_TADD, S_FIN
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_LOAD, OP_READ, OP_PREP, OP_PARAM, OP_XSQ, OP_XPSET,
        OP_MUL, OP_DIV, OP_RADD, OP_RSHF, OP_CONV, OP_FACC, OP_PFSET, OP_PSET,
        OP_CPSET, OP_TADD, OP_FIN
    } op_t;

    typedef enum logic [1:0] {
        PH_TERM, PH_PROD, PH_COEF
    } phase_t;

    typedef enum logic [1:0] {
        C_ONE, C_FIRST, C_LAST, C_MID
    } case_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] k;
        phase_t     phase;
        logic [2:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic is_term;
        logic last_dim;
        logic last_point;
        logic t1_div3;
        logic out_busy;
    } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/sgsm_ctrl.sv =====
// Sequencer that steps the datapath through loads and grid point terms.
`default_nettype none
module sgsm_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire sgsm_pkg::sts_t sts,
    output sgsm_pkg::cmd_t     cmd,
    output logic               busy
);

    sgsm_pkg::state_t state_reg, state_next;
    sgsm_pkg::phase_t phase_reg, phase_next;
    logic [1:0]       k_reg, k_next;
    logic [2:0]       cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgsm_pkg::S_IDLE;
            phase_reg <= sgsm_pkg::PH_TERM;
            k_reg     <= 2'd0;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        cmd.op     = sgsm_pkg::OP_NONE;
        cmd.k      = k_reg;
        cmd.phase  = phase_reg;
        cmd.cnt    = cnt_reg;
        busy       = 1'b1;
        case (state_reg)
            sgsm_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (accept)
                begin
                    cmd.op     = sgsm_pkg::OP_LATCH;
                    state_next = sgsm_pkg::S_READ;
                end
            end
            sgsm_pkg::S_READ:
            begin
                if (sts.is_term)
                begin
                    cmd.op     = sgsm_pkg::OP_READ;
                    state_next = sgsm_pkg::S_PREP;
                end
                else
                begin
                    cmd.op     = sgsm_pkg::OP_LOAD;
                    state_next = sgsm_pkg::S_IDLE;
                end
            end
            sgsm_pkg::S_PREP:
            begin
                cmd.op     = sgsm_pkg::OP_PREP;
                state_next = sgsm_pkg::S_PARAM;
            end
            sgsm_pkg::S_PARAM:
            begin
                cmd.op     = sgsm_pkg::OP_PARAM;
                state_next = sgsm_pkg::S_XSQ;
                k_next     = 2'd2;
                phase_next = sgsm_pkg::PH_TERM;
            end
            sgsm_pkg::S_XSQ:
            begin
                cmd.op     = sgsm_pkg::OP_XSQ;
                state_next = sgsm_pkg::S_XPSET;
            end
            sgsm_pkg::S_XPSET:
            begin
                cmd.op     = sgsm_pkg::OP_XPSET;
                state_next = sgsm_pkg::S_MUL;
                cnt_next   = 3'd0;
            end
            sgsm_pkg::S_MUL:
            begin
                cmd.op   = sgsm_pkg::OP_MUL;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    cnt_next = 3'd0;
                    // The squared term always carries a /3; the first-moment term carries one only in the edge cases.
                    if (phase_reg == sgsm_pkg::PH_TERM &&
                        (k_reg == 2'd2 || (k_reg == 2'd1 && sts.t1_div3)))
                        state_next = sgsm_pkg::S_DIV;
                    else
                        state_next = sgsm_pkg::S_RADD;
                end
            end
            sgsm_pkg::S_DIV:
            begin
                cmd.op   = sgsm_pkg::OP_DIV;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                    state_next = sgsm_pkg::S_RADD;
            end
            sgsm_pkg::S_RADD:
            begin
                cmd.op     = sgsm_pkg::OP_RADD;
                state_next = sgsm_pkg::S_RSHF;
            end
            sgsm_pkg::S_RSHF:
            begin
                cmd.op     = sgsm_pkg::OP_RSHF;
                state_next = sgsm_pkg::S_CONV;
            end
            sgsm_pkg::S_CONV:
            begin
                cmd.op = sgsm_pkg::OP_CONV;
                case (phase_reg)
                    sgsm_pkg::PH_TERM: state_next = sgsm_pkg::S_FACC;
                    sgsm_pkg::PH_PROD: state_next = sgsm_pkg::S_PSET;
                    default:           state_next = sgsm_pkg::S_TADD;
                endcase
            end
            sgsm_pkg::S_FACC:
            begin
                cmd.op = sgsm_pkg::OP_FACC;
                if (k_reg == 2'd0)
                begin
                    state_next = sgsm_pkg::S_PFSET;
                    phase_next = sgsm_pkg::PH_PROD;
                end
                else
                begin
                    k_next     = k_reg - 2'd1;
                    state_next = sgsm_pkg::S_XSQ;
                end
            end
            sgsm_pkg::S_PFSET:
            begin
                cmd.op     = sgsm_pkg::OP_PFSET;
                state_next = sgsm_pkg::S_MUL;
                cnt_next   = 3'd0;
            end
            sgsm_pkg::S_PSET:
            begin
                cmd.op = sgsm_pkg::OP_PSET;
                if (sts.last_dim)
                begin
                    state_next = sgsm_pkg::S_CPSET;
                    phase_next = sgsm_pkg::PH_COEF;
                end
                else
                    state_next = sgsm_pkg::S_FIN;
            end
            sgsm_pkg::S_CPSET:
            begin
                cmd.op     = sgsm_pkg::OP_CPSET;
                state_next = sgsm_pkg::S_MUL;
                cnt_next   = 3'd0;
            end
            sgsm_pkg::S_TADD:
            begin
                cmd.op     = sgsm_pkg::OP_TADD;
                state_next = sgsm_pkg::S_FIN;
            end
            sgsm_pkg::S_FIN:
            begin
                // Hold a last-point term here while the previous result still sits, stalled, in the output register.
                if (!(sts.last_point && sts.out_busy))
                begin
                    cmd.op     = sgsm_pkg::OP_FIN;
                    state_next = sgsm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sgsm_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/sgsm_datapath.sv =====
// Bound memory, shared multiplier, divide-by-three, rounding and accumulators.
`default_nettype none
module sgsm_datapath #(
    parameter int DIMS      = sgsm_pkg::DIMS_DEF,
    parameter int MAX_LEVEL = sgsm_pkg::MAX_LEVEL_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sgsm_pkg::cmd_t  cmd,
    input  wire sgsm_pkg::item_t item,
    input  wire logic            result_stall,
    output sgsm_pkg::sts_t       sts,
    output logic                 result_valid,
    output sgsm_pkg::result_t    result
);

    localparam int AW = (DIMS > 1) ? $clog2(DIMS) : 1;

    function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            sat_add = {1'b1, s[64] ? sgsm_pkg::S64_MIN : sgsm_pkg::S64_MAX};
        else
            sat_add = {1'b0, s[63:0]};
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        mag64 = v[63] ? (~v + 64'd1) : v;
    endfunction

    logic [63:0]       bound_mem [DIMS];
    logic [DIMS-1:0]   valid_reg;
    logic [63:0]       rd_reg;
    logic              rd_ok_reg;

    sgsm_pkg::item_t   item_reg;
    logic [31:0]       xw_reg, xw_next, xl_reg, xl_next;
    logic              w_neg_reg, w_neg_next, xl_neg_reg, xl_neg_next;
    logic [4:0]        lvl_reg, lvl_next;
    sgsm_pkg::case_t   case_reg, case_next;
    logic [31:0]       ii_reg, ii_next;
    logic [63:0]       p2_reg, p2_next, p1_reg, p1_next;
    logic [1:0]        p0_reg, p0_next;
    logic [sgsm_pkg::SHIFT_W-1:0] s2_reg, s2_next, s1_reg, s1_next, s0_reg, s0_next;
    logic              div1_reg, div1_next;
    logic [63:0]       opa_reg, opa_next, opb_reg, opb_next;
    logic [127:0]      acc_reg, acc_next;
    logic [1:0]        rem_reg, rem_next;
    logic              neg_reg, neg_next;
    logic [63:0]       res_reg, res_next;
    logic [63:0]       fac_reg, fac_next;
    logic [63:0]       prod_reg, prod_next;
    logic [63:0]       total_reg, total_next;
    logic              flag_reg, flag_next;
    logic              out_valid_reg, out_valid_next;
    sgsm_pkg::result_t out_reg, out_next;

    logic [AW-1:0]     addr;
    logic              in_range;
    logic [31:0]       ma, mb;
    logic [63:0]       mprod;
    logic [17:0]       dcur;
    logic [35:0]       dprod;
    logic [15:0]       dq;
    logic [17:0]       drem;
    logic [sgsm_pkg::SHIFT_W-1:0] rshift;
    logic [31:0]       lo_b, up_b;
    logic [32:0]       w33;
    logic [4:0]        lv;
    logic [31:0]       h32;
    logic [63:0]       h64, h2;
    logic [6:0]        l3;
    logic [64:0]       sa;

    assign addr     = AW'(item_reg.dimension);
    assign in_range = 32'(item_reg.dimension) < DIMS;

    // Bound table: valid bits stand in for the reset values of unwritten entries.
    always_ff @(posedge clk)
    begin
        if (cmd.op == sgsm_pkg::OP_LOAD && in_range)
            bound_mem[addr] <= {item_reg.upper_bound, item_reg.lower_bound};
        if (cmd.op == sgsm_pkg::OP_READ)
            rd_reg <= bound_mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == sgsm_pkg::OP_LOAD && in_range)
                valid_reg[addr] <= 1'b1;
            if (cmd.op == sgsm_pkg::OP_READ)
                rd_ok_reg <= in_range && valid_reg[addr];
        end
    end

    // Shared 32x32 multiplier.
    always_comb
    begin
        ma = opa_reg[31:0];
        mb = opb_reg[31:0];
        if (cmd.op == sgsm_pkg::OP_XSQ)
        begin
            case (cmd.k)
                2'd2:    begin ma = xw_reg; mb = xw_reg; end
                2'd1:    begin ma = xw_reg; mb = xl_reg; end
                default: begin ma = xl_reg; mb = xl_reg; end
            endcase
        end
        else
        begin
            ma = cmd.cnt[1] ? opa_reg[63:32] : opa_reg[31:0];
            mb = cmd.cnt[0] ? opb_reg[63:32] : opb_reg[31:0];
        end
    end
    assign mprod = ma * mb;

    // Divide by three, 16 bits a step, most significant chunk first.
    assign dcur  = {(cmd.cnt == 3'd0) ? 2'd0 : rem_reg, acc_reg[127:112]};
    assign dprod = dcur * 18'd174763;
    assign dq    = dprod[34:19];
    assign drem  = dcur - {1'b0, dq, 1'b0} - {2'b00, dq};

    always_comb
    begin
        case (cmd.phase)
            sgsm_pkg::PH_TERM:
            begin
                case (cmd.k)
                    2'd2:    rshift = s2_reg;
                    2'd1:    rshift = s1_reg;
                    default: rshift = s0_reg;
                endcase
            end
            sgsm_pkg::PH_PROD: rshift = 7'd40;
            default:           rshift = 7'd24;
        endcase
    end

    assign lo_b = rd_ok_reg ? rd_reg[31:0] : 32'd0;
    assign up_b = rd_ok_reg ? rd_reg[63:32] : sgsm_pkg::ONE_Q24;
    assign w33  = {up_b[31], up_b} - {lo_b[31], lo_b};
    assign lv   = (item_reg.level == 5'd0) ? 5'd1 :
                  (32'(item_reg.level) > MAX_LEVEL) ? 5'(MAX_LEVEL) : item_reg.level;
    assign h32  = 32'd1 << lv;
    assign h64  = 64'd1 << lvl_reg;
    assign h2   = 64'd1 << {lvl_reg, 1'b0};
    assign l3   = {1'b0, lvl_reg, 1'b0} + {2'b00, lvl_reg};

    always_comb
    begin
        xw_next     = xw_reg;
        xl_next     = xl_reg;
        w_neg_next  = w_neg_reg;
        xl_neg_next = xl_neg_reg;
        lvl_next    = lvl_reg;
        case_next   = case_reg;
        ii_next     = ii_reg;
        p2_next     = p2_reg;
        p1_next     = p1_reg;
        p0_next     = p0_reg;
        s2_next     = s2_reg;
        s1_next     = s1_reg;
        s0_next     = s0_reg;
        div1_next   = div1_reg;
        opa_next    = opa_reg;
        opb_next    = opb_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        res_next    = res_reg;
        fac_next    = fac_reg;
        prod_next   = prod_reg;
        total_next  = total_reg;
        flag_next   = flag_reg;
        sa          = '0;
        out_next    = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        case (cmd.op)
            sgsm_pkg::OP_PREP:
            begin
                xw_next     = w33[32] ? 32'(~w33 + 33'd1) : w33[31:0];
                xl_next     = lo_b[31] ? (~lo_b + 32'd1) : lo_b;
                w_neg_next  = w33[32];
                xl_neg_next = lo_b[31];
                lvl_next    = lv;
                ii_next     = item_reg.index * item_reg.index;
                if (lv == 5'd1)
                    case_next = sgsm_pkg::C_ONE;
                else if (item_reg.index == 16'd1)
                    case_next = sgsm_pkg::C_FIRST;
                else if ({16'd0, item_reg.index} == h32 - 32'd1)
                    case_next = sgsm_pkg::C_LAST;
                else
                    case_next = sgsm_pkg::C_MID;
            end
            sgsm_pkg::OP_PARAM:
            begin
                case (case_reg)
                    sgsm_pkg::C_ONE:
                    begin
                        p2_next = 64'd1; s2_next = 7'd8;
                        p1_next = 64'd1; s1_next = 7'd8; div1_next = 1'b0;
                        p0_next = 2'd1;  s0_next = 7'd8;
                    end
                    sgsm_pkg::C_FIRST:
                    begin
                        p2_next = 64'd4; s2_next = l3 + 7'd8;
                        p1_next = 64'd8; s1_next = {1'b0, lvl_reg, 1'b0} + 7'd8;
                        div1_next = 1'b1;
                        p0_next = 2'd2;  s0_next = {2'b00, lvl_reg} + 7'd8;
                    end
                    sgsm_pkg::C_LAST:
                    begin
                        p2_next = ((h2 << 1) + h2 - (h64 << 2) + 64'd2) << 1;
                        s2_next = l3 + 7'd8;
                        p1_next = ((h64 << 1) + h64 - 64'd2) << 2;
                        s1_next = {1'b0, lvl_reg, 1'b0} + 7'd8;
                        div1_next = 1'b1;
                        p0_next = 2'd2;  s0_next = {2'b00, lvl_reg} + 7'd8;
                    end
                    default:
                    begin
                        p2_next = ({32'd0, ii_reg} << 2) + ({32'd0, ii_reg} << 1) + 64'd1;
                        s2_next = l3 + 7'd9;
                        p1_next = {47'd0, item_reg.index, 1'b0};
                        s1_next = {1'b0, lvl_reg, 1'b0} + 7'd8;
                        div1_next = 1'b0;
                        p0_next = 2'd1;  s0_next = {2'b00, lvl_reg} + 7'd8;
                    end
                endcase
            end
            sgsm_pkg::OP_XSQ:
            begin
                acc_next = {64'd0, mprod};
                neg_next = (cmd.k == 2'd1) ? (w_neg_reg ^ xl_neg_reg) : 1'b0;
            end
            sgsm_pkg::OP_XPSET:
            begin
                opa_next = acc_reg[63:0];
                case (cmd.k)
                    2'd2:    opb_next = p2_reg;
                    2'd1:    opb_next = p1_reg;
                    default: opb_next = {62'd0, p0_reg};
                endcase
                acc_next = '0;
            end
            sgsm_pkg::OP_MUL:
            begin
                case (cmd.cnt[1:0])
                    2'd0:    acc_next = acc_reg + {64'd0, mprod};
                    2'd3:    acc_next = acc_reg + {mprod, 64'd0};
                    default: acc_next = acc_reg + {32'd0, mprod, 32'd0};
                endcase
            end
            sgsm_pkg::OP_DIV:
            begin
                acc_next = {acc_reg[111:0], dq};
                rem_next = drem[1:0];
            end
            sgsm_pkg::OP_RADD:
            begin
                acc_next = acc_reg + (128'd1 << (rshift - 7'd1));
            end
            sgsm_pkg::OP_RSHF:
            begin
                acc_next = acc_reg >> rshift;
            end
            sgsm_pkg::OP_CONV:
            begin
                if (neg_reg)
                begin
                    if ((|acc_reg[127:64]) || acc_reg[63:0] > sgsm_pkg::S64_MIN)
                    begin
                        res_next  = sgsm_pkg::S64_MIN;
                        flag_next = 1'b1;
                    end
                    else
                        res_next = ~acc_reg[63:0] + 64'd1;
                end
                else
                begin
                    if ((|acc_reg[127:64]) || acc_reg[63])
                    begin
                        res_next  = sgsm_pkg::S64_MAX;
                        flag_next = 1'b1;
                    end
                    else
                        res_next = acc_reg[63:0];
                end
            end
            sgsm_pkg::OP_FACC:
            begin
                if (cmd.k == 2'd2)
                    fac_next = res_reg;
                else
                begin
                    sa        = sat_add(fac_reg, res_reg);
                    fac_next  = sa[63:0];
                    flag_next = flag_reg | sa[64];
                end
            end
            sgsm_pkg::OP_PFSET:
            begin
                opa_next = mag64(prod_reg);
                opb_next = mag64(fac_reg);
                neg_next = prod_reg[63] ^ fac_reg[63];
                acc_next = '0;
            end
            sgsm_pkg::OP_PSET:
            begin
                prod_next = res_reg;
            end
            sgsm_pkg::OP_CPSET:
            begin
                opa_next = mag64({{32{item_reg.coefficient[31]}}, item_reg.coefficient});
                opb_next = mag64(prod_reg);
                neg_next = item_reg.coefficient[31] ^ prod_reg[63];
                acc_next = '0;
            end
            sgsm_pkg::OP_TADD:
            begin
                sa         = sat_add(total_reg, res_reg);
                total_next = sa[63:0];
                flag_next  = flag_reg | sa[64];
            end
            sgsm_pkg::OP_FIN:
            begin
                if (item_reg.last_dim || item_reg.last_point)
                    prod_next = sgsm_pkg::ONE_Q40;
                if (item_reg.last_point)
                begin
                    out_next.moment_total = total_reg;
                    out_next.overflow     = flag_reg;
                    out_valid_next        = 1'b1;
                    total_next            = '0;
                    flag_next             = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == sgsm_pkg::OP_LATCH)
            item_reg <= item;
        xw_reg     <= xw_next;
        xl_reg     <= xl_next;
        w_neg_reg  <= w_neg_next;
        xl_neg_reg <= xl_neg_next;
        lvl_reg    <= lvl_next;
        case_reg   <= case_next;
        ii_reg     <= ii_next;
        p2_reg     <= p2_next;
        p1_reg     <= p1_next;
        p0_reg     <= p0_next;
        s2_reg     <= s2_next;
        s1_reg     <= s1_next;
        s0_reg     <= s0_next;
        div1_reg   <= div1_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        res_reg    <= res_next;
        fac_reg    <= fac_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg      <= sgsm_pkg::ONE_Q40;
            total_reg     <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prod_reg      <= prod_next;
            total_reg     <= total_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.is_term    = item_reg.command == sgsm_pkg::CMD_TERM;
    assign sts.last_dim   = item_reg.last_dim;
    assign sts.last_point = item_reg.last_point;
    assign sts.t1_div3    = div1_reg;
    assign sts.out_busy   = out_valid_reg && result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

// ===== rtl/core/sparse_grid_second_moment_accumulator.sv =====
// Top level of the sparse-grid second-moment accumulator.
//
// Items arrive on item_valid/item_stall/item; an item is taken at a clock edge with
// item_valid high and item_stall low. A load item writes the lower and upper bound of
// one dimension. In a term item every product goes through one shared 32x32
// multiplier as four partial products, and the terms with a factor of one third
// pass a divider that retires 16 bits a cycle over a 128-bit word. item_stall is
// high for the whole time an item is being worked on. A term marked last_point
// puts the saturated Q24.40 total and the overflow flag into an output register
// on result_valid/result_stall, then clears the total. While the receiver stalls
// the result holds, and the next items are still taken; only a further last-point
// term waits until the held result is gone. Reset sets every bound to 0 and 1.0,
// the point product to 1.0 and the total and flag to 0; no result is pending
// after reset.
`default_nettype none
`include "assert_macros.svh"
module sparse_grid_second_moment_accumulator #(
    parameter int DIMS      = sgsm_pkg::DIMS_DEF,
    parameter int MAX_LEVEL = sgsm_pkg::MAX_LEVEL_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire sgsm_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output sgsm_pkg::result_t      result
);

    sgsm_pkg::cmd_t cmd;
    sgsm_pkg::sts_t sts;
    logic           busy;
    logic           accept;
    logic           first_op;

    assign item_stall = busy;
    assign accept     = item_valid && !item_stall;
    assign first_op   = cmd.op == sgsm_pkg::OP_READ || cmd.op == sgsm_pkg::OP_LOAD;

    sgsm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    sgsm_datapath #(
        .DIMS      (DIMS),
        .MAX_LEVEL (MAX_LEVEL)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .result_stall (result_stall),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

    `ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept, item_stall)
    `ASSERT_NXT(a_read_after_accept, clk, rst_n, accept, first_op)
    `ASSERT_NXT(a_result_only_from_fin, clk, rst_n, !result_valid && cmd.op != sgsm_pkg::OP_FIN, !result_valid)

endmodule
`default_nettype wire
